// ===== rtl/core/kps_pkg.sv =====
// Shared constants, types and helpers for the knob parameter selector.
`default_nettype none

package kps_pkg;

    localparam int NUM_PARAMS = 3;
    localparam int AP_W       = $clog2(NUM_PARAMS);

    localparam int VAL_W      = 16;
    localparam int LEVEL_W    = 24;
    localparam int TIMER_W    = 10;
    localparam int TICK_W     = 8;
    localparam int BLINK_W    = 9;
    localparam int ZONE_W     = 2;
    localparam int LED_W      = 3;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [TIMER_W-1:0] TIMER_MAX    = 10'd1023;
    localparam logic [TIMER_W:0]   BLINK_PERIOD = 11'd500;
    localparam logic [BLINK_W-1:0] BLINK_ON     = 9'd200;
    localparam logic [TIMER_W-1:0] FLASH_ON1    = 10'd120;
    localparam logic [TIMER_W-1:0] FLASH_OFF1   = 10'd240;
    localparam logic [TIMER_W-1:0] FLASH_ON2    = 10'd360;
    localparam logic [TIMER_W-1:0] FLASH_END    = 10'd480;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 24'hFFFF00;

    typedef logic [ZONE_W-1:0] t_zone;
    localparam t_zone ZONE_LOW  = 2'd0;
    localparam t_zone ZONE_MID  = 2'd1;
    localparam t_zone ZONE_HIGH = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 3'd0,
        CFG_LOWER    = 3'd1,
        CFG_UPPER    = 3'd2,
        CFG_MARGIN   = 3'd3,
        CFG_WINDOW   = 3'd4,
        CFG_IDLE_LVL = 3'd5,
        CFG_DEBOUNCE = 3'd6,
        CFG_TICK     = 3'd7
    } t_cfg_idx;

    function automatic logic [AP_W-1:0] next_param(input logic [AP_W-1:0] ap);
        logic [AP_W-1:0] r;
        if (ap == AP_W'(NUM_PARAMS - 1)) begin
            r = '0;
        end else begin
            r = ap + AP_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kps_ema.sv =====
// Fixed-point exponential smoother: one multiply, rounding, clamp and knob rounding.
`default_nettype none

module kps_ema (
    input  wire logic [kps_pkg::LEVEL_W-1:0] i_level,
    input  wire logic [kps_pkg::VAL_W-1:0]   i_pot,
    input  wire logic [kps_pkg::VAL_W-1:0]   i_gain,
    output logic      [kps_pkg::LEVEL_W-1:0] o_level,
    output logic      [kps_pkg::VAL_W-1:0]   o_knob
);
    import kps_pkg::*;

    logic signed [LEVEL_W:0]   diff;
    logic signed [LEVEL_W+VAL_W+1:0] prod;
    logic signed [LEVEL_W+VAL_W+1:0] acc;
    logic        [LEVEL_W:0]   s_full;
    logic        [LEVEL_W:0]   knob_rnd;

    // s*(1-g) + p*g == s + g*(p - s): one signed 17x25 product
    always_comb begin
        diff     = $signed({1'b0, i_pot, 8'b0}) - $signed({1'b0, i_level});
        prod     = $signed({1'b0, i_gain}) * diff;
        acc      = $signed({2'b0, i_level, 16'b0}) + prod
                 + $signed((LEVEL_W+VAL_W+2)'(32768));
        s_full   = acc[LEVEL_W+VAL_W:VAL_W];
        if (s_full > {1'b0, LEVEL_MAX}) begin
            o_level = LEVEL_MAX;
        end else begin
            o_level = s_full[LEVEL_W-1:0];
        end
        knob_rnd = {1'b0, o_level} + (LEVEL_W+1)'(128);
        if (knob_rnd[LEVEL_W]) begin
            o_knob = '1;
        end else begin
            o_knob = knob_rnd[LEVEL_W-1:8];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/knob_param_selector_with_pickup_top.sv =====
// Top level: knob smoother, soft takeover, button cycling, zone hysteresis and LED display.
`default_nettype none

// One control tick per input word; a word is accepted every cycle while the
// output side keeps up. The input register loads on acceptance and the result
// register loads when that word advances, which waits while the output stalls.
// The rate is set by the per-tick state update (smoother multiply, pickup
// compare, button and zone logic), which is combinational between the input
// and result registers. The user must write registers through the cfg port
// only while no word is in flight; the block itself does not enforce this.
module knob_param_selector_with_pickup_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [kps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [kps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] pot_sample, [16] button_level, [23:17] zero
    input  wire logic [kps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [2:0] led_mask, [4:3] active_index, [6:5] zone_index,
    // [22:7] param_value, [23] picked_up
    output logic      [kps_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import kps_pkg::*;

    // configuration
    logic [VAL_W-1:0]   r_gain, r_lower, r_upper, r_margin, r_window;
    logic               r_idle_lvl;
    logic [TIMER_W-1:0] r_debounce;
    logic [TICK_W-1:0]  r_tick;

    // input register
    logic               r_in_valid;
    logic [VAL_W-1:0]   r_pot;
    logic               r_btn;

    // tick state
    logic [LEVEL_W-1:0]    r_level;
    logic [VAL_W-1:0]      r_store [NUM_PARAMS];
    logic [VAL_W-1:0]      r_cur, r_nxt;
    logic [NUM_PARAMS-1:0] r_flags;
    logic [AP_W-1:0]       r_active;
    t_zone                 r_zone;
    logic                  r_prev_down;
    logic [TIMER_W-1:0]    r_deb_tmr, r_flash_tmr;
    logic [BLINK_W-1:0]    r_blink;
    logic                  r_flashing, r_seeded;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic advance;

    logic [LEVEL_W-1:0]    lvl0, n_level;
    logic [VAL_W-1:0]      knob, cur0, cur1, n_cur, n_nxt, knob_gap;
    t_zone                 zone0, n_zone;
    logic [TIMER_W:0]      deb_sum, flash_sum, blink_sum;
    logic [TIMER_W-1:0]    n_deb_tmr, n_flash_tmr;
    logic [BLINK_W-1:0]    n_blink;
    logic                  flag0, flag1, down, press, n_flashing, flash_on;
    logic [NUM_PARAMS-1:0] n_flags;
    logic [AP_W-1:0]       n_active, rd_addr;
    logic [VAL_W:0]        lower_hi, upper_hi, val_lo;
    logic [LED_W-1:0]      led;

    function automatic t_zone plain_zone(input logic [VAL_W-1:0] v,
                                         input logic [VAL_W-1:0] lo,
                                         input logic [VAL_W-1:0] hi);
        t_zone z;
        if (v < lo) begin
            z = ZONE_LOW;
        end else if (v < hi) begin
            z = ZONE_MID;
        end else begin
            z = ZONE_HIGH;
        end
        return z;
    endfunction

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // the first word seeds the smoother and parameter 0 (active is 0 then)
    assign lvl0  = r_seeded ? r_level : {r_pot, 8'b0};
    assign cur0  = r_seeded ? r_cur : r_pot;
    assign zone0 = r_seeded ? r_zone : plain_zone(r_pot, r_lower, r_upper);

    kps_ema u_ema (
        .i_level (lvl0),
        .i_pot   (r_pot),
        .i_gain  (r_gain),
        .o_level (n_level),
        .o_knob  (knob)
    );

    always_comb begin
        deb_sum   = {1'b0, r_deb_tmr} + (TIMER_W+1)'(r_tick);
        flash_sum = {1'b0, r_flash_tmr} + (TIMER_W+1)'(r_tick);
        blink_sum = (TIMER_W+1)'(r_blink) + (TIMER_W+1)'(r_tick);
        n_deb_tmr   = deb_sum[TIMER_W] ? TIMER_MAX : deb_sum[TIMER_W-1:0];
        n_flash_tmr = flash_sum[TIMER_W] ? TIMER_MAX : flash_sum[TIMER_W-1:0];
        if (blink_sum >= BLINK_PERIOD) begin
            n_blink = BLINK_W'(blink_sum - BLINK_PERIOD);
        end else begin
            n_blink = blink_sum[BLINK_W-1:0];
        end

        // soft takeover
        flag0    = r_flags[r_active];
        flag1    = flag0;
        cur1     = cur0;
        knob_gap = (knob > cur0) ? (knob - cur0) : (cur0 - knob);
        if (flag0) begin
            cur1 = knob;
        end else if (knob_gap < r_window) begin
            flag1   = 1'b1;
            n_blink = '0;
        end
        n_flags           = r_flags;
        n_flags[r_active] = flag1;

        // button: debounced rising edge cycles the active parameter
        down        = r_btn ^ r_idle_lvl;
        press       = down && !r_prev_down && (n_deb_tmr > r_debounce);
        n_active    = r_active;
        n_cur       = cur1;
        n_nxt       = r_nxt;
        n_zone      = zone0;
        n_flashing  = r_flashing;
        rd_addr     = next_param(next_param(r_active));
        if (press) begin
            n_deb_tmr         = '0;
            n_active          = next_param(r_active);
            n_flags[n_active] = 1'b0;
            n_blink           = '0;
            n_cur             = r_nxt;
            // with two parameters the one after next is the one just left
            n_nxt             = (rd_addr == r_active) ? cur1 : r_store[rd_addr];
            n_zone            = plain_zone(r_nxt, r_lower, r_upper);
            n_flashing        = 1'b1;
            n_flash_tmr       = '0;
        end

        // hysteresis, first matching move only
        lower_hi = {1'b0, r_lower} + {1'b0, r_margin};
        upper_hi = {1'b0, r_upper} + {1'b0, r_margin};
        val_lo   = {1'b0, n_cur} + {1'b0, r_margin};
        if (n_zone == ZONE_LOW && {1'b0, n_cur} > lower_hi) begin
            n_zone = ZONE_MID;
        end else if (n_zone == ZONE_MID && val_lo < {1'b0, r_lower}) begin
            n_zone = ZONE_LOW;
        end else if (n_zone == ZONE_MID && {1'b0, n_cur} > upper_hi) begin
            n_zone = ZONE_HIGH;
        end else if (n_zone == ZONE_HIGH && val_lo < {1'b0, r_upper}) begin
            n_zone = ZONE_MID;
        end

        // LED display
        led      = '0;
        flash_on = (n_flash_tmr < FLASH_ON1) ||
                   (n_flash_tmr >= FLASH_OFF1 && n_flash_tmr < FLASH_ON2);
        if (n_flashing) begin
            if (flash_on && (32'(n_active) < LED_W)) begin
                led = LED_W'(1) << n_active;
            end
            if (n_flash_tmr > FLASH_END) begin
                n_flashing = 1'b0;
            end
        end else if (!n_flags[n_active]) begin
            led = (n_blink < BLINK_ON) ? '1 : '0;
        end else begin
            led = LED_W'(1) << n_zone;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= 16'd6554;
            r_lower    <= 16'd21627;
            r_upper    <= 16'd43253;
            r_margin   <= 16'd1966;
            r_window   <= 16'd1966;
            r_idle_lvl <= 1'b1;
            r_debounce <= 10'd200;
            r_tick     <= 8'd20;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN:     r_gain     <= i_cfg_data;
                CFG_LOWER:    r_lower    <= i_cfg_data;
                CFG_UPPER:    r_upper    <= i_cfg_data;
                CFG_MARGIN:   r_margin   <= i_cfg_data;
                CFG_WINDOW:   r_window   <= i_cfg_data;
                CFG_IDLE_LVL: r_idle_lvl <= i_cfg_data[0];
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[TIMER_W-1:0];
                CFG_TICK:     r_tick     <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_pot <= s_axis_tdata[VAL_W-1:0];
            r_btn <= s_axis_tdata[VAL_W];
        end
    end

    // tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            for (int i = 0; i < NUM_PARAMS; i++) begin
                r_store[i] <= '0;
            end
            r_cur       <= '0;
            r_nxt       <= '0;
            r_flags     <= NUM_PARAMS'(1);
            r_active    <= '0;
            r_zone      <= ZONE_LOW;
            r_prev_down <= 1'b0;
            r_deb_tmr   <= '0;
            r_flash_tmr <= '0;
            r_blink     <= '0;
            r_flashing  <= 1'b1;
            r_seeded    <= 1'b0;
        end else if (advance) begin
            r_level           <= n_level;
            r_store[r_active] <= cur1;
            r_cur             <= n_cur;
            r_nxt             <= n_nxt;
            r_flags           <= n_flags;
            r_active          <= n_active;
            r_zone            <= n_zone;
            r_prev_down       <= down;
            r_deb_tmr         <= n_deb_tmr;
            r_flash_tmr       <= n_flash_tmr;
            r_blink           <= n_blink;
            r_flashing        <= n_flashing;
            r_seeded          <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_data <= {n_flags[n_active], n_cur, n_zone, IDX_W'(n_active), led};
        end
    end

endmodule

`default_nettype wire
